[sv/dfs_pkg.sv]
// Package for the depth-first search timestamp block: beat types, codes,
// controller states and the command/status structs.
// No dependencies.
package dfs_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int RESULT_LIMIT     = 32;
    localparam int CFG_W            = 6;
    localparam int TIME_W           = 7;
    localparam int VID_W            = 5;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 6'd32;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [VID_W-1:0] from_vertex;
        logic [VID_W-1:0] to_vertex;
    } in_item_t;

    typedef struct packed {
        logic [VID_W-1:0]  vertex_index;
        logic              visited;
        logic [TIME_W-1:0] discovery_time;
        logic [TIME_W-1:0] finish_time;
        logic              has_predecessor;
        logic [VID_W-1:0]  predecessor;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } dfs_state_t;

    typedef struct packed {
        logic clear_arcs;
        logic add_arc;
        logic load_run;
        logic step;
        logic emit;
    } dfs_cmd_t;

    typedef struct packed {
        logic stack_empty;
        logic emit_last;
    } dfs_stat_t;

endpackage

[sv/dfs_ctrl.sv]
// Controller for the depth-first search block: accepts commands and
// sequences the walk and result phases. Depends on dfs_pkg.
module dfs_ctrl
    import dfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] operation,
    input  dfs_stat_t stat,
    output logic      busy,
    output dfs_cmd_t  cmd
);

    dfs_state_t state_reg;
    dfs_state_t state_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_RUN))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.stack_empty)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy           = 1'b1;
        cmd.clear_arcs = 1'b0;
        cmd.add_arc    = 1'b0;
        cmd.load_run   = 1'b0;
        cmd.step       = 1'b0;
        cmd.emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.clear_arcs = accept && (operation == OP_CLEAR);
                cmd.add_arc    = accept && (operation == OP_ADD);
                cmd.load_run   = accept && (operation == OP_RUN);
            end
            ST_WALK:
            begin
                cmd.step = !stat.stack_empty;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // one command at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("controller issued two commands at once");

    a_run_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_run |=> busy)
        else $error("run accepted but controller stayed idle");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.emit_last) |=> !busy)
        else $error("controller did not return to idle after last result");

endmodule

[sv/dfs_dpath.sv]
// Datapath for the depth-first search block: adjacency rows, visited marks,
// time stores, walk stack, neighbor scan and result register. Depends on dfs_pkg.
module dfs_dpath
    import dfs_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         item,
    input  dfs_cmd_t         cmd,
    input  logic [CFG_W-1:0] vertex_count,
    output dfs_stat_t        stat,
    output out_item_t        result,
    output logic             result_strobe
);

    localparam int VMAX = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;
    localparam int VW   = $clog2(VMAX);
    localparam int SPW  = $clog2(VMAX + 1);
    localparam int NXW  = VW + 1;

    logic [VMAX-1:0]   adj_reg [VMAX];
    logic [VMAX-1:0]   vis_reg;
    logic [TIME_W-1:0] disc_mem [VMAX];
    logic [TIME_W-1:0] fin_mem [VMAX];
    logic [VW-1:0]     par_v_mem [VMAX];
    logic              par_has_mem [VMAX];
    logic [VW-1:0]     stk_v_mem [VMAX];
    logic [NXW-1:0]    stk_n_mem [VMAX];

    logic [VW-1:0]     cur_v_reg,  cur_v_next;
    logic [NXW-1:0]    cur_n_reg,  cur_n_next;
    logic [SPW-1:0]    sp_reg,     sp_next;
    logic [TIME_W-1:0] time_reg,   time_next;
    logic [CFG_W-1:0]  n_reg,      n_next;
    logic [VW-1:0]     emit_reg,   emit_next;
    out_item_t         result_reg;
    logic              strobe_reg;

    logic [CFG_W-1:0]  n_cfg;
    logic              start_ok;
    logic              add_ok;
    logic [VW-1:0]     sv;
    logic [VW-1:0]     av;
    logic [VW-1:0]     bv;
    logic [VMAX-1:0]   row;
    logic [VMAX-1:0]   cand;
    logic              found;
    logic [VW-1:0]     u;
    logic [TIME_W-1:0] time_inc;
    logic [SPW-1:0]    sp_m1;
    logic [SPW-1:0]    sp_m2;
    logic              emit_last;
    logic              e_vis;
    logic              e_has;

    // vertex count in use: zero acts as one, clamp to storage
    always_comb
    begin
        if (vertex_count == '0)
        begin
            n_cfg = CFG_W'(1);
        end
        else if (vertex_count > CFG_W'(VMAX))
        begin
            n_cfg = CFG_W'(VMAX);
        end
        else
        begin
            n_cfg = vertex_count;
        end
    end

    assign start_ok = CFG_W'(item.from_vertex) < n_cfg;
    assign add_ok   = (CFG_W'(item.from_vertex) < CFG_W'(VMAX))
                   && (CFG_W'(item.to_vertex) < CFG_W'(VMAX));
    assign sv       = VW'(item.from_vertex);
    assign av       = VW'(item.from_vertex);
    assign bv       = VW'(item.to_vertex);

    // lowest unvisited neighbor at or above the resume point
    assign row = adj_reg[cur_v_reg];

    always_comb
    begin
        for (int k = 0; k < VMAX; k++)
        begin
            cand[k] = row[k] && !vis_reg[k] && (CFG_W'(k) < n_reg)
                   && (NXW'(k) >= cur_n_reg);
        end
    end

    always_comb
    begin
        found = 1'b0;
        u     = '0;
        for (int k = VMAX - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                found = 1'b1;
                u     = VW'(k);
            end
        end
    end

    assign time_inc = time_reg + TIME_W'(1);
    assign sp_m1    = sp_reg - SPW'(1);
    assign sp_m2    = sp_reg - SPW'(2);

    always_comb
    begin
        cur_v_next = cur_v_reg;
        cur_n_next = cur_n_reg;
        sp_next    = sp_reg;
        time_next  = time_reg;
        n_next     = n_reg;
        emit_next  = emit_reg;
        if (cmd.load_run)
        begin
            n_next     = n_cfg;
            cur_v_next = sv;
            cur_n_next = '0;
            sp_next    = start_ok ? SPW'(1) : '0;
            time_next  = start_ok ? TIME_W'(1) : '0;
            emit_next  = '0;
        end
        if (cmd.step)
        begin
            time_next = time_inc;
            if (found)
            begin
                cur_v_next = u;
                cur_n_next = '0;
                sp_next    = sp_reg + SPW'(1);
            end
            else
            begin
                sp_next = sp_m1;
                if (sp_reg > SPW'(1))
                begin
                    cur_v_next = stk_v_mem[sp_m2[VW-1:0]];
                    cur_n_next = stk_n_mem[sp_m2[VW-1:0]];
                end
            end
        end
        if (cmd.emit)
        begin
            emit_next = emit_reg + VW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg <= '0;
            cur_n_reg <= '0;
            sp_reg    <= '0;
            time_reg  <= '0;
            n_reg     <= CFG_W'(1);
            emit_reg  <= '0;
        end
        else
        begin
            cur_v_reg <= cur_v_next;
            cur_n_reg <= cur_n_next;
            sp_reg    <= sp_next;
            time_reg  <= time_next;
            n_reg     <= n_next;
            emit_reg  <= emit_next;
        end
    end

    // adjacency rows and visited marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VMAX; k++)
            begin
                adj_reg[k] <= '0;
            end
            vis_reg <= '0;
        end
        else
        begin
            if (cmd.clear_arcs)
            begin
                for (int k = 0; k < VMAX; k++)
                begin
                    adj_reg[k] <= '0;
                end
            end
            if (cmd.add_arc && add_ok)
            begin
                adj_reg[av][bv] <= 1'b1;
            end
            // run start: only the start vertex is marked, none if it is not in use
            if (cmd.load_run)
            begin
                vis_reg <= start_ok ? (VMAX'(1) << sv) : '0;
            end
            if (cmd.step && found)
            begin
                vis_reg[u] <= 1'b1;
            end
        end
    end

    // per-vertex stores and stack, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_run && start_ok)
        begin
            disc_mem[sv]    <= TIME_W'(1);
            par_has_mem[sv] <= 1'b0;
        end
        if (cmd.step && found)
        begin
            stk_v_mem[sp_m1[VW-1:0]] <= cur_v_reg;
            stk_n_mem[sp_m1[VW-1:0]] <= NXW'(u) + NXW'(1);
            disc_mem[u]              <= time_inc;
            par_has_mem[u]           <= 1'b1;
            par_v_mem[u]             <= cur_v_reg;
        end
        if (cmd.step && !found)
        begin
            fin_mem[cur_v_reg] <= time_inc;
        end
    end

    // result beat
    assign emit_last = CFG_W'(emit_reg) == (n_reg - CFG_W'(1));
    assign e_vis     = vis_reg[emit_reg];
    assign e_has     = e_vis && par_has_mem[emit_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.vertex_index    <= VID_W'(emit_reg);
            result_reg.visited         <= e_vis;
            result_reg.discovery_time  <= e_vis ? disc_mem[emit_reg] : '0;
            result_reg.finish_time     <= e_vis ? fin_mem[emit_reg] : '0;
            result_reg.has_predecessor <= e_has;
            result_reg.predecessor     <= e_has ? VID_W'(par_v_mem[emit_reg]) : '0;
            result_reg.last            <= emit_last;
        end
    end

    assign result           = result_reg;
    assign result_strobe    = strobe_reg;
    assign stat.stack_empty = (sp_reg == '0);
    assign stat.emit_last   = emit_last;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(VMAX))
        else $error("walk stack overflow");

    a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (sp_reg != '0))
        else $error("stack step issued on empty stack");

    a_emit_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (sp_reg == '0))
        else $error("result emitted while walk unfinished");

    a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=> !result_strobe)
        else $error("result beat after last");

endmodule

[sv/dfs_discovery_finish_times.sv]
// Top level of the depth-first search timestamp block: APB register,
// controller and datapath. Depends on dfs_pkg, dfs_ctrl, dfs_dpath.
//
// Use:
//   Command channel: present item and raise start; the beat is taken at a
//   rising edge with start high and busy low. operation selects clear all
//   arcs, add one arc (from_vertex -> to_vertex) or run a search from
//   from_vertex. Clear and add leave busy low.
//   A run walks the graph with a stack, one push or pop per cycle (the
//   neighbor scan over the current row is the per-cycle limit), and it
//   holds busy while it walks and while it issues N result beats, N =
//   vertices in use, vertex 0 first, one per cycle, each on result for
//   exactly one cycle with result_strobe high; the last beat has
//   result.last set and shows in the cycle in which busy drops. Each
//   beat is registered from the result phase, which follows the walk.
//   The receiver cannot stall; beats are never held.
//   Config: vertex_count at APB byte address 0 (6 bits, reset 32);
//   write only while idle. pready is always high.
//   Reset (rst_n low, async) empties the graph, sets vertex_count to 32
//   and returns the block to idle.
module dfs_discovery_finish_times
    import dfs_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output out_item_t   result,
    output logic        result_strobe,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CFG_W-1:0] vertex_count_reg;
    logic [CFG_W-1:0] vertex_count_next;
    logic             reg_sel;
    dfs_cmd_t         cmd;
    dfs_stat_t        stat;

    // register index is paddr[2]; only index 0 exists
    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;

    always_comb
    begin
        vertex_count_next = vertex_count_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            vertex_count_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RST;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    assign prdata = reg_sel ? 32'(vertex_count_reg) : '0;

    dfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .stat      (stat),
        .busy      (busy),
        .cmd       (cmd)
    );

    dfs_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .vertex_count  (vertex_count_reg),
        .stat          (stat),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule
